// ===== rtl/bd2x_pkg.sv =====
// Shared types, format codes and per-channel lane arithmetic for the 2x box downsampler.
package bd2x_pkg;

    // Pixel format codes
    localparam logic [2:0] FMT_L8    = 3'd0;
    localparam logic [2:0] FMT_LA8   = 3'd1;
    localparam logic [2:0] FMT_D16   = 3'd2;
    localparam logic [2:0] FMT_RGB8  = 3'd3;
    localparam logic [2:0] FMT_RGBA8 = 3'd4;
    localparam logic [2:0] FMT_D24S8 = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int PIXEL_W    = 32;
    localparam int PAIR_W     = 36;
    localparam int CFG_DATA_W = 16;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [PAIR_W-1:0]  t_pair;

    // Per-pixel decisions from the raster position
    typedef struct packed {
        logic hold;         // capture first pixel of a pair
        logic store_write;  // write pair sum to the line store
        logic emit;         // pair completes a result
        logic one_d;        // single row or single column image
        logic done;         // last result of the image
    } t_pos_ctrl;

    // Sum of two 8-bit channels into a 9-bit lane
    function automatic logic [8:0] add8(input logic [7:0] a, input logic [7:0] b);
        return {1'b0, a} + {1'b0, b};
    endfunction

    // Average of two 9-bit pair-sum lanes down to 8 bits
    function automatic logic [7:0] avg9(input logic [8:0] p, input logic [8:0] q);
        logic [9:0] s;
        s = {1'b0, p} + {1'b0, q};
        return s[9:2];
    endfunction

    // Pack per-channel pair sums of two pixels, each lane one bit wider than its channel
    function automatic t_pair pair_pack(input logic [2:0] fmt, input t_pixel a, input t_pixel b);
        t_pair p;
        p = '0;
        unique case (fmt)
            FMT_L8: begin
                p[8:0] = add8(a[7:0], b[7:0]);
            end
            FMT_LA8: begin
                p[8:0]  = add8(a[7:0], b[7:0]);
                p[17:9] = add8(a[15:8], b[15:8]);
            end
            FMT_D16: begin
                p[16:0] = {1'b0, a[15:0]} + {1'b0, b[15:0]};
            end
            FMT_RGB8: begin
                p[8:0]   = add8(a[7:0], b[7:0]);
                p[17:9]  = add8(a[15:8], b[15:8]);
                p[26:18] = add8(a[23:16], b[23:16]);
            end
            FMT_D24S8: begin
                p[24:0]  = {1'b0, a[23:0]} + {1'b0, b[23:0]};
                p[33:25] = add8(a[31:24], b[31:24]);
            end
            default: begin
                // RGBA8 and unused codes
                p[8:0]   = add8(a[7:0], b[7:0]);
                p[17:9]  = add8(a[15:8], b[15:8]);
                p[26:18] = add8(a[23:16], b[23:16]);
                p[35:27] = add8(a[31:24], b[31:24]);
            end
        endcase
        return p;
    endfunction

    // Add two packed pair sums per lane, divide by four, repack as a pixel
    function automatic t_pixel combine(input logic [2:0] fmt, input t_pair p, input t_pair q);
        t_pixel     o;
        logic [17:0] s16;
        logic [25:0] s24;
        o   = '0;
        s16 = {1'b0, p[16:0]} + {1'b0, q[16:0]};
        s24 = {1'b0, p[24:0]} + {1'b0, q[24:0]};
        unique case (fmt)
            FMT_L8: begin
                o[7:0] = avg9(p[8:0], q[8:0]);
            end
            FMT_LA8: begin
                o[7:0]  = avg9(p[8:0], q[8:0]);
                o[15:8] = avg9(p[17:9], q[17:9]);
            end
            FMT_D16: begin
                o[15:0] = s16[17:2];
            end
            FMT_RGB8: begin
                o[7:0]   = avg9(p[8:0], q[8:0]);
                o[15:8]  = avg9(p[17:9], q[17:9]);
                o[23:16] = avg9(p[26:18], q[26:18]);
            end
            FMT_D24S8: begin
                o[23:0]  = s24[25:2];
                o[31:24] = avg9(p[33:25], q[33:25]);
            end
            default: begin
                o[7:0]   = avg9(p[8:0], q[8:0]);
                o[15:8]  = avg9(p[17:9], q[17:9]);
                o[23:16] = avg9(p[26:18], q[26:18]);
                o[31:24] = avg9(p[35:27], q[35:27]);
            end
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/bd2x_sdp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module bd2x_sdp_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bd2x_position.sv =====
// Raster position counters and per-pixel pairing decisions.
module bd2x_position
    import bd2x_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int ADDR_W    = ((MAX_WIDTH / 2) > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_restart,
    input  logic [12:0]       i_image_width,
    input  logic [15:0]       i_image_height,
    output t_pos_ctrl         o_ctrl,
    output logic [ADDR_W-1:0] o_pair_index
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    logic [COL_W-1:0] r_col, n_col;
    logic [15:0]      r_row, n_row;

    logic [31:0]      width_ext;
    logic [WID_W-1:0] w_eff, hw, col_ext;
    logic [15:0]      h_eff, hh;
    logic             w2, h2, col_in, row_in, last_col, last_row, done_2d;

    // Clamp the configured size
    always_comb begin
        width_ext = {19'd0, i_image_width};
        if (width_ext == 32'd0) begin
            w_eff = WID_W'(1);
        end else if (width_ext > 32'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(width_ext);
        end
        h_eff = (i_image_height == 16'd0) ? 16'd1 : i_image_height;
    end

    assign hw      = {w_eff[WID_W-1:1], 1'b0};
    assign hh      = {h_eff[15:1], 1'b0};
    assign w2      = (w_eff > WID_W'(1));
    assign h2      = (h_eff > 16'd1);
    assign col_ext = WID_W'(r_col);
    assign col_in  = (col_ext < hw);
    assign row_in  = (r_row < hh);
    assign last_col = (col_ext == w_eff - WID_W'(1));
    assign last_row = (r_row == h_eff - 16'd1);
    assign done_2d  = (r_row == hh - 16'd1) && (col_ext == hw - WID_W'(1));

    // Decide what the current pixel does
    always_comb begin
        o_ctrl = '0;
        priority if (w2 && h2) begin
            o_ctrl.hold        = row_in && col_in && !r_col[0];
            o_ctrl.store_write = row_in && col_in && r_col[0] && !r_row[0];
            o_ctrl.emit        = row_in && col_in && r_col[0] && r_row[0];
            o_ctrl.done        = done_2d;
        end else if (w2) begin
            o_ctrl.hold  = col_in && !r_col[0];
            o_ctrl.emit  = col_in && r_col[0];
            o_ctrl.one_d = 1'b1;
            o_ctrl.done  = (col_ext == hw - WID_W'(1));
        end else if (h2) begin
            o_ctrl.hold  = row_in && !r_row[0];
            o_ctrl.emit  = row_in && r_row[0];
            o_ctrl.one_d = 1'b1;
            o_ctrl.done  = (r_row == hh - 16'd1);
        end else begin
            o_ctrl = '0;
        end
    end

    assign o_pair_index = ADDR_W'(r_col >> 1);

    // Advance in raster order, wrap at the end of the image
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? 16'd0 : r_row + 16'd1;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/box_downsample_2x_unit.sv =====
// Top level of the 2x2 box-filter downsampler for raster pixel streams.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------------------------
//  source   | in        | i_in_valid / o_in_ready      | i_source_pixel
//  result   | out       | o_out_valid / i_out_ready    | o_averaged_pixel, o_image_done
//  config   | in        | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// One source pixel per cycle is accepted while the pair-sum stage is empty or can hand on its result.
// A result passes from its completing pixel to the pair-sum stage, which also covers the
// line store's registered read, and is then combined into the output register.
// Reset is synchronous and clears control state and the held pixel; the line store is not
// cleared and needs no clearing pass, since every entry is written on an even row before it is read.
// With the output stalled, o_in_ready stays high until the pair-sum stage holds a result.
module box_downsample_2x_unit
    import bd2x_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIXEL_W-1:0]    i_source_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_W-1:0]    o_averaged_pixel,
    output logic                  o_image_done,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [2:0]  r_pixel_format;
    logic [12:0] r_image_width;
    logic [15:0] r_image_height;
    logic        cfg_hit;

    t_pos_ctrl         ctrl;
    logic [ADDR_W-1:0] pair_index;
    logic              accept, out_load;
    t_pair             pair_now, store_rd, pair_other;
    t_pixel            r_held_pixel;

    logic   r_s1_valid, n_s1_valid;
    t_pair  r_s1_pair;
    logic   r_s1_one_d, r_s1_done;
    logic   r_out_valid, n_out_valid;
    t_pixel r_out_pixel;
    logic   r_out_done;

    // Configuration registers
    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == CFG_FORMAT || i_cfg_index == CFG_WIDTH ||
                      i_cfg_index == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_RGBA8;
            r_image_width  <= 13'd1;
            r_image_height <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_pixel_format <= i_cfg_data[2:0];
                CFG_WIDTH:  r_image_width  <= i_cfg_data[12:0];
                CFG_HEIGHT: r_image_height <= i_cfg_data;
                default:    r_pixel_format <= r_pixel_format;
            endcase
        end
    end

    // Handshakes: the pair-sum stage takes new input when it is empty or loads the output register
    assign out_load   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign accept     = i_in_valid && o_in_ready;

    bd2x_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_position (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (accept),
        .i_restart      (cfg_hit),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_ctrl         (ctrl),
        .o_pair_index   (pair_index)
    );

    // Pair sums of the held pixel and the incoming one
    assign pair_now = pair_pack(r_pixel_format, r_held_pixel, i_source_pixel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pixel <= '0;
        end else if (accept && ctrl.hold) begin
            r_held_pixel <= i_source_pixel;
        end
    end

    // Line store: even rows write pair sums, odd rows read them back
    bd2x_sdp_ram #(
        .WIDTH  (PAIR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && ctrl.store_write),
        .i_wr_addr (pair_index),
        .i_wr_data (pair_now),
        .i_rd_en   (accept && ctrl.emit && !ctrl.one_d),
        .i_rd_addr (pair_index),
        .o_rd_data (store_rd)
    );

    // Pair-sum stage
    always_comb begin
        if (accept) begin
            n_s1_valid = ctrl.emit;
        end else if (out_load) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && ctrl.emit) begin
            r_s1_pair  <= pair_now;
            r_s1_one_d <= ctrl.one_d;
            r_s1_done  <= ctrl.done;
        end
    end

    // Combine with the stored row, or with itself for a one-dimensional image
    assign pair_other = r_s1_one_d ? r_s1_pair : store_rd;

    // Output register
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pixel <= combine(r_pixel_format, r_s1_pair, pair_other);
            r_out_done  <= r_s1_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_averaged_pixel = r_out_pixel;
    assign o_image_done     = r_out_done;

endmodule

// ===== tb/sv/tb_box_downsample_2x_unit.sv =====
// Self-checking testbench for the 2x2 box-filter downsampler top level.
module tb_box_downsample_2x_unit;
    import bd2x_pkg::*;

    localparam int          MAX_W         = 4096;
    localparam int          RANDOM_ITEMS  = 1880;
    localparam int          WIDE_ITEMS    = 48;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          PHASE_CAP     = 240;
    localparam int          TIMEOUT       = 40_000_000;
    localparam logic [2:0]  FMT_UNUSED    = 3'd7;
    // Register select mask bits for one configuration phase
    localparam logic [2:0]  SEL_FORMAT    = 3'b001;
    localparam logic [2:0]  SEL_WIDTH     = 3'b010;
    localparam logic [2:0]  SEL_HEIGHT    = 3'b100;
    localparam logic [2:0]  SEL_ALL       = 3'b111;

    typedef logic [3:0][24:0] lane_sums_t;

    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][4:0] pos;
        logic [3:0][4:0] wid;
    } chan_map_t;

    typedef struct packed {
        t_pixel pixel;
        logic   done;
    } result_t;

    typedef struct packed {
        logic       is_cfg;
        logic [1:0] reg_idx;
        logic [15:0] reg_data;
        t_pixel     pixel;
        logic       typed;
        logic       want;
        t_pixel     want_pixel;
        logic       want_done;
    } stim_row_t;

    localparam int N_DIRECTED = 36;

    // Directed stimulus; typed rows carry their own expected result
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},           // 1x1 after reset
        '{1'b1, CFG_WIDTH, 16'd2, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_HEIGHT, 16'd1, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},           // single row
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h0000_0000, 1'b1, 1'b1, 32'h7F7F_7F7F, 1'b1},
        '{1'b1, CFG_FORMAT, 16'(FMT_LA8), '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h1234_5678, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h9ABC_DEF0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_FORMAT, 16'(FMT_D16), '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h0000_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFFFF_0001, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_FORMAT, 16'(FMT_RGB8), '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h5A5A_5A5B, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_FORMAT, 16'(FMT_D24S8), '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_WIDTH, 16'd1, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_HEIGHT, 16'd2, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},           // single column
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{1'b1, CFG_WIDTH, 16'd2, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h00FF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},           // 2x2 depth carry
        '{1'b0, '0, '0, 32'h00FF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFF00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFF00_0001, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_HEIGHT, 16'd1, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_FORMAT, 16'(FMT_UNUSED), '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h0101_0101, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'h0202_0202, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_FORMAT, 16'(FMT_L8), '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hFFFF_FFFE, 1'b1, 1'b1, 32'h0000_00FE, 1'b1},
        '{1'b1, CFG_WIDTH, 16'd0, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b1, CFG_HEIGHT, 16'd0, '0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, '0, '0, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0, 1'b0}            // zero size acts 1x1
    };

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [PIXEL_W-1:0]    i_source_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [PIXEL_W-1:0]    o_averaged_pixel;
    logic                  o_image_done;
    logic                  i_cfg_we       = 1'b0;
    logic [1:0]            i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Predictor state
    logic [2:0]   fmt_reg    = FMT_RGBA8;
    logic [12:0]  width_reg  = 13'd1;
    logic [15:0]  height_reg = 16'd1;
    t_pixel       held_px    = '0;
    int unsigned  col_pos    = 0;
    int unsigned  row_pos    = 0;
    lane_sums_t   even_row_sums [MAX_W/2];

    result_t      pending_averages [$];
    int           fail_count  = 0;
    int           sent_items  = 0;
    int unsigned  cycle_count = 0;
    int unsigned  stall_mode  = 0;
    int unsigned  stall_left  = 0;

    box_downsample_2x_unit #(.MAX_WIDTH(MAX_W)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_source_pixel   (i_source_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_averaged_pixel (o_averaged_pixel),
        .o_image_done     (o_image_done),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT);
        $display("status: fail");
        $finish;
    end

    // Channel positions and widths for a format code
    function automatic chan_map_t channel_map(input logic [2:0] fmt);
        chan_map_t m;
        m = '0;
        case (fmt)
            FMT_L8: begin
                m.count = 3'd1; m.wid[0] = 5'd8;
            end
            FMT_LA8: begin
                m.count = 3'd2; m.wid[0] = 5'd8; m.pos[1] = 5'd8; m.wid[1] = 5'd8;
            end
            FMT_D16: begin
                m.count = 3'd1; m.wid[0] = 5'd16;
            end
            FMT_RGB8: begin
                m.count = 3'd3;
                m.wid[0] = 5'd8; m.pos[1] = 5'd8; m.wid[1] = 5'd8;
                m.pos[2] = 5'd16; m.wid[2] = 5'd8;
            end
            FMT_D24S8: begin
                m.count = 3'd2; m.wid[0] = 5'd24; m.pos[1] = 5'd24; m.wid[1] = 5'd8;
            end
            default: begin
                m.count = 3'd4;
                m.wid[0] = 5'd8; m.pos[1] = 5'd8; m.wid[1] = 5'd8;
                m.pos[2] = 5'd16; m.wid[2] = 5'd8; m.pos[3] = 5'd24; m.wid[3] = 5'd8;
            end
        endcase
        return m;
    endfunction

    // Per-channel sums of a horizontal or vertical pixel pair
    function automatic lane_sums_t pair_sums(input logic [2:0] fmt, input t_pixel a,
                                             input t_pixel b);
        chan_map_t  m;
        lane_sums_t s;
        t_pixel     mask;
        logic [24:0] va;
        logic [24:0] vb;
        m = channel_map(fmt);
        s = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < m.count) begin
                mask = (32'd1 << m.wid[i]) - 32'd1;
                va   = 25'((a >> m.pos[i]) & mask);
                vb   = 25'((b >> m.pos[i]) & mask);
                s[i] = va + vb;
            end
        end
        return s;
    endfunction

    // Add two sets of pair sums, divide by four and repack
    function automatic t_pixel box_average(input logic [2:0] fmt, input lane_sums_t p,
                                           input lane_sums_t q);
        chan_map_t   m;
        t_pixel      o;
        t_pixel      mask;
        t_pixel      chan;
        logic [25:0] s;
        m = channel_map(fmt);
        o = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < m.count) begin
                mask = (32'd1 << m.wid[i]) - 32'd1;
                s    = {1'b0, p[i]} + {1'b0, q[i]};
                chan = t_pixel'(s >> 2) & mask;
                o    = o | (chan << m.pos[i]);
            end
        end
        return o;
    endfunction

    // Advance the predictor by one source pixel
    task automatic downsample_step(input t_pixel px, output bit got, output result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned hw;
        int unsigned hh;
        lane_sums_t  cur;
        w = width_reg;
        h = height_reg;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h < 1) h = 1;
        hw   = (w / 2) * 2;
        hh   = (h / 2) * 2;
        got  = 1'b0;
        res  = '0;
        if (w >= 2 && h >= 2) begin
            if (row_pos < hh && col_pos < hw) begin
                if (col_pos % 2 == 0) begin
                    held_px = px;
                end else begin
                    cur = pair_sums(fmt_reg, held_px, px);
                    if (row_pos % 2 == 0) begin
                        even_row_sums[col_pos / 2] = cur;
                    end else begin
                        res.pixel = box_average(fmt_reg, cur, even_row_sums[col_pos / 2]);
                        res.done  = (row_pos == hh - 1) && (col_pos == hw - 1);
                        got       = 1'b1;
                    end
                end
            end
        end else if (w >= 2) begin
            if (col_pos < hw) begin
                if (col_pos % 2 == 0) begin
                    held_px = px;
                end else begin
                    cur       = pair_sums(fmt_reg, held_px, px);
                    res.pixel = box_average(fmt_reg, cur, cur);
                    res.done  = (col_pos == hw - 1);
                    got       = 1'b1;
                end
            end
        end else if (h >= 2) begin
            if (row_pos < hh) begin
                if (row_pos % 2 == 0) begin
                    held_px = px;
                end else begin
                    cur       = pair_sums(fmt_reg, held_px, px);
                    res.pixel = box_average(fmt_reg, cur, cur);
                    res.done  = (row_pos == hh - 1);
                    got       = 1'b1;
                end
            end
        end
        // Advance the raster position
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // Drive one register write; the caller drops the write enable after the group
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_FORMAT: fmt_reg    = data[2:0];
            CFG_WIDTH:  width_reg  = data[12:0];
            CFG_HEIGHT: height_reg = data;
            default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // Hold valid until the source transaction completes, then predict its result
    task automatic send_pixel(input t_pixel px, input bit typed, input bit want,
                              input result_t want_res);
        bit      got;
        result_t res;
        i_in_valid     <= 1'b1;
        i_source_pixel <= px;
        do @(posedge i_clk); while (!o_in_ready);
        downsample_step(px, got, res);
        if (typed) begin
            got = want;
            res = want_res;
        end
        if (got) pending_averages.push_back(res);
        sent_items++;
    endtask

    // Wait until every expected result is out and the pipeline is empty
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Configure an image and stream pixels into it in bursts
    task automatic image_phase(input logic [15:0] fdata, input logic [15:0] wdata,
                               input logic [15:0] hdata, input logic [2:0] sel,
                               input int n_force);
        int unsigned w;
        int unsigned h;
        int unsigned img;
        int          n;
        int          burst_left;
        int          gap;
        bit          no_gaps;
        drain_pipeline();
        if (sel & SEL_FORMAT) cfg_write(CFG_FORMAT, fdata);
        if (sel & SEL_WIDTH)  cfg_write(CFG_WIDTH, wdata);
        if (sel & SEL_HEIGHT) cfg_write(CFG_HEIGHT, hdata);
        i_cfg_we <= 1'b0;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        img = w * h;
        if (n_force > 0) begin
            n = n_force;
        end else begin
            // Mostly whole images, sometimes cut short by the next register write
            if ($urandom_range(0, 3) != 0) n = img * $urandom_range(1, 3);
            else n = $urandom_range(1, 2 * img);
            if (n > PHASE_CAP) n = PHASE_CAP;
        end
        no_gaps    = ($urandom_range(0, 4) == 0);
        burst_left = $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
            send_pixel(random_pixel(), 1'b0, 1'b0, '0);
            burst_left--;
            if (burst_left == 0 && k != n - 1) begin
                gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // Receiver backpressure: switch between randomly chosen stall patterns
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ((cycle_count % 8) >= 5);
        endcase
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_averages.size() == 0) begin
                $error("unexpected result: averaged_pixel %h image_done %b",
                       o_averaged_pixel, o_image_done);
                fail_count++;
            end else begin
                want = pending_averages.pop_front();
                if (o_averaged_pixel !== want.pixel) begin
                    $error("averaged_pixel expected %h actual %h", want.pixel, o_averaged_pixel);
                    fail_count++;
                end
                if (o_image_done !== want.done) begin
                    $error("image_done expected %b actual %b", want.done, o_image_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t   row;
        logic [15:0] fdata;
        logic [15:0] wdata;
        logic [15:0] hdata;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.is_cfg) begin
                if (i == 0 || !DIRECTED[i-1].is_cfg) drain_pipeline();
                cfg_write(row.reg_idx, row.reg_data);
                if (i == N_DIRECTED - 1 || !DIRECTED[i+1].is_cfg) i_cfg_we <= 1'b0;
            end else begin
                send_pixel(row.pixel, row.typed, row.want,
                           result_t'{row.want_pixel, row.want_done});
            end
        end

        // Random images, mostly small, with unused data bits randomized
        while (sent_items < RANDOM_ITEMS) begin
            fdata      = 16'($urandom);
            fdata[2:0] = 3'($urandom_range(0, 7));
            wdata      = 16'($urandom);
            case ($urandom_range(0, 15))
                0: wdata[12:0] = '0;
                1: wdata[12:0] = 13'($urandom_range(17, 80));
                default: wdata[12:0] = 13'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 15))
                0: hdata = '0;
                1: hdata = '1;
                2: hdata = 16'($urandom_range(9, 60000));
                default: hdata = 16'($urandom_range(1, 8));
            endcase
            image_phase(fdata, wdata, hdata, 3'($urandom_range(1, 7)), 0);
        end

        // Start of an over-wide row, clamped to the line store width
        image_phase(16'($urandom_range(0, 7)), 16'h1FFF, 16'd1, SEL_ALL, WIDE_ITEMS);

        drain_pipeline();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
